FILE: hw/rtl/edgefx_pkg.sv
package edgefx_pkg;

  localparam int MAX_GRID_WIDTH  = 512;
  localparam int MAX_GRID_HEIGHT = 1024;
  localparam int COL_W           = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W           = $clog2(MAX_GRID_HEIGHT);
  localparam int WIDTH_REG_W     = 10;
  localparam int HEIGHT_REG_W    = 11;
  localparam int CFG_DATA_W      = 11;

  localparam logic [WIDTH_REG_W-1:0]  GRID_WIDTH_RESET  = 10'd160;
  localparam logic [HEIGHT_REG_W-1:0] GRID_HEIGHT_RESET = 11'd120;

  localparam logic [24:0] CARRY_MASK = 25'h1010100;
  localparam logic [10:0] RG_CAP     = 11'd127;
  localparam logic [11:0] B_CAP      = 12'd255;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // One entry of the line store: the pixel and its horizontal gradient.
  typedef struct packed {
    logic [23:0] pixel;
    logic [23:0] hgrad;
  } line_word_t;

  typedef struct packed {
    logic [24:0] above_left;
    logic [24:0] above_own;
    logic [24:0] own_left;
    logic [24:0] own_own;
    logic [23:0] hgrad;
    logic [23:0] vgrad;
  } mix_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  function automatic logic [23:0] gradient(input logic [23:0] p, input logic [23:0] q);
    logic [10:0] r;
    logic [10:0] g;
    logic [11:0] b;
    logic [6:0]  rc;
    logic [6:0]  gc;
    logic [7:0]  bc;
    r  = 11'(sq_diff(p[23:16], q[23:16]) >> 5);
    g  = 11'(sq_diff(p[15:8], q[15:8]) >> 5);
    b  = 12'(sq_diff(p[7:0], q[7:0]) >> 4);
    rc = (r > RG_CAP) ? RG_CAP[6:0] : r[6:0];
    gc = (g > RG_CAP) ? RG_CAP[6:0] : g[6:0];
    bc = (b > B_CAP) ? B_CAP[7:0] : b[7:0];
    return {rc, 1'b0, gc, 1'b0, bc};
  endfunction

  // A carry out of a byte fills that byte with ones.
  function automatic logic [24:0] sat_add(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    logic [24:0] c;
    s = 25'(a) + 25'(b);
    c = s & CARRY_MASK;
    return s | (c - (c >> 8));
  endfunction

endpackage

FILE: hw/rtl/edgefx_line_mem.sv
module edgefx_line_mem (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [edgefx_pkg::COL_W-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [edgefx_pkg::COL_W-1:0]  wr_addr,
  input  edgefx_pkg::line_word_t        wr_data,
  output edgefx_pkg::line_word_t        rd_data
);
  import edgefx_pkg::*;

  line_word_t mem [MAX_GRID_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the column being written in the same cycle takes the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: hw/rtl/edgefx_mix.sv
module edgefx_mix (
  input  logic [23:0]             pixel,
  input  logic [23:0]             left_pixel,
  input  logic [23:0]             left_vgrad,
  input  edgefx_pkg::line_word_t  upper,
  input  logic                    is_interior,
  output edgefx_pkg::mix_t        mix
);
  import edgefx_pkg::*;

  logic [23:0] own_h;
  logic [23:0] own_v;

  assign own_h = is_interior ? gradient(pixel, left_pixel) : '0;
  assign own_v = is_interior ? gradient(pixel, upper.pixel) : '0;

  always_comb begin
    mix = '0;
    if (is_interior) begin
      mix.above_left = sat_add(upper.hgrad, left_vgrad);
      mix.above_own  = sat_add(upper.hgrad, own_v);
      mix.own_left   = sat_add(own_h, left_vgrad);
      mix.own_own    = sat_add(own_h, own_v);
      mix.hgrad      = own_h;
      mix.vgrad      = own_v;
    end
  end

endmodule

FILE: hw/rtl/block_edge_video_effect.sv
// Edge effect on a grid that takes every fourth pixel of every fourth line.
// Grid pixels enter in raster order on the pixel channel (pixel_valid,
// pixel_ready, red, green, blue, frame_start); frame_start on a word sets
// the position back to the top left corner before that word is used.
// Each grid pixel gives one word on the block channel (block_valid,
// block_ready): the position of its 4x4 output block, an interior flag and
// the four mixed and two plain gradient words. Border blocks carry zeros.
// The grid size is set through cfg_we, cfg_index and cfg_data while the
// block is idle: index 0 is the grid width, index 1 the grid height.
// A word accepted on the pixel channel is held in the gradient stage and
// then in the output register, which drives the block channel. One word is
// taken every cycle while the receiver keeps up; the limit is the single
// line store port pair, read on accept and written when the word leaves
// the gradient stage. When the receiver stalls, one word waits in the
// output register and one in the gradient stage before pixel_ready drops.
// Reset sets the grid to 160 by 120 and the position to zero; the line
// store is not cleared and holds valid data once the first row has passed.
module block_edge_video_effect (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [edgefx_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  pixel_valid,
  output logic                                  pixel_ready,
  input  logic [7:0]                            red,
  input  logic [7:0]                            green,
  input  logic [7:0]                            blue,
  input  logic                                  frame_start,
  output logic                                  block_valid,
  input  logic                                  block_ready,
  output logic                                  interior,
  output logic [8:0]                            block_col,
  output logic [9:0]                            block_row,
  output logic [24:0]                           mix_above_left,
  output logic [24:0]                           mix_above_own,
  output logic [24:0]                           mix_own_left,
  output logic [24:0]                           mix_own_own,
  output logic [23:0]                           horiz_gradient,
  output logic [23:0]                           vert_gradient
);
  import edgefx_pkg::*;

  logic [WIDTH_REG_W-1:0]  grid_width;
  logic [HEIGHT_REG_W-1:0] grid_height;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] row0;
  logic             inside0;
  logic             col_last;
  logic             row_last;
  logic             accept;

  logic             s1_valid;
  logic             s1_adv;
  logic [23:0]      s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_inside;

  logic [23:0]      left_pixel;
  logic [23:0]      left_vgrad;
  line_word_t       upper;
  line_word_t       wr_word;
  mix_t             mix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width > WIDTH_REG_W'(MAX_GRID_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_GRID_WIDTH);
    end else if (grid_width == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height > HEIGHT_REG_W'(MAX_GRID_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_GRID_HEIGHT);
    end else if (grid_height == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else begin
      h_eff = grid_height;
    end
  end

  // Handshake and pipeline advance.
  assign s1_adv      = s1_valid && (!block_valid || block_ready);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  // Position of the incoming word.
  assign col0 = frame_start ? '0 : col_count;
  assign row0 = frame_start ? '0 : row_count;

  assign inside0 = (col0 != '0) && (row0 != '0)
                 && ((11'(col0) + 11'd2) <= 11'(w_eff))
                 && ((12'(row0) + 12'd2) <= 12'(h_eff));
  assign col_last = (10'(col0) + 10'd1) >= 10'(w_eff);
  assign row_last = (11'(row0) + 11'd1) >= 11'(h_eff);

  always_comb begin
    col_count_next = col0 + COL_W'(1);
    row_count_next = row0;
    if (col_last) begin
      col_count_next = '0;
      row_count_next = row_last ? '0 : (row0 + ROW_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Gradient stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= {red, green, blue};
      s1_col    <= col0;
      s1_row    <= row0;
      s1_inside <= inside0;
    end
  end

  assign wr_word.pixel = s1_pixel;
  assign wr_word.hgrad = mix.hgrad;

  edgefx_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col0),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_word),
    .rd_data (upper)
  );

  edgefx_mix u_mix (
    .pixel       (s1_pixel),
    .left_pixel  (left_pixel),
    .left_vgrad  (left_vgrad),
    .upper       (upper),
    .is_interior (s1_inside),
    .mix         (mix)
  );

  // The left neighbor is updated when a word leaves the gradient stage.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_pixel <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_vgrad <= '0;
    end else if (s1_adv) begin
      left_vgrad <= mix.vgrad;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= 1'b0;
    end else if (s1_adv) begin
      block_valid <= 1'b1;
    end else if (block_ready) begin
      block_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      interior       <= s1_inside;
      block_col      <= s1_col;
      block_row      <= s1_row;
      mix_above_left <= mix.above_left;
      mix_above_own  <= mix.above_own;
      mix_own_left   <= mix.own_left;
      mix_own_own    <= mix.own_own;
      horiz_gradient <= mix.hgrad;
      vert_gradient  <= mix.vgrad;
    end
  end

  a_border_black: assert property (@(posedge clk) disable iff (rst)
    block_valid && !interior |-> (mix_own_own == '0) && (horiz_gradient == '0)
      && (vert_gradient == '0) && (mix_above_left == '0))
    else $error("border block carries nonzero values");

  a_interior_pos: assert property (@(posedge clk) disable iff (rst)
    block_valid && interior |-> (block_col != '0) && (block_row != '0))
    else $error("interior block on the first row or column");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_pixel))
    else $error("gradient stage word lost while stalled");

endmodule

FILE: tb/edgefx_block_checker.sv
module edgefx_block_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [edgefx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              pixel_valid,
  input  logic                              pixel_ready,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  input  logic                              frame_start,
  input  logic                              block_valid,
  input  logic                              block_ready,
  input  logic                              interior,
  input  logic [8:0]                        block_col,
  input  logic [9:0]                        block_row,
  input  logic [24:0]                       mix_above_left,
  input  logic [24:0]                       mix_above_own,
  input  logic [24:0]                       mix_own_left,
  input  logic [24:0]                       mix_own_own,
  input  logic [23:0]                       horiz_gradient,
  input  logic [23:0]                       vert_gradient,
  output int                                failures,
  output int                                pending
);
  import edgefx_pkg::*;

  typedef struct packed {
    logic        interior;
    logic [8:0]  col;
    logic [9:0]  row;
    logic [24:0] above_left;
    logic [24:0] above_own;
    logic [24:0] own_left;
    logic [24:0] own_own;
    logic [23:0] hgrad;
    logic [23:0] vgrad;
  } block_word_t;

  block_word_t expected_blocks[$];
  int          mismatch_count;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [23:0] above_pix [MAX_GRID_WIDTH];
  logic [23:0] above_hgrad [MAX_GRID_WIDTH];
  logic [23:0] prev_pix;
  logic [23:0] prev_vgrad;
  int unsigned col_pos;
  int unsigned row_pos;

  initial begin
    mismatch_count = 0;
    prev_pix = '0;
    for (int i = 0; i < MAX_GRID_WIDTH; i++) begin
      above_pix[i] = '0;
      above_hgrad[i] = '0;
    end
  end

  // Squared channel difference, scaled and clamped, packed as r:g:b with a
  // spare zero bit above green and blue that takes the carry of a sum.
  function automatic logic [23:0] edge_strength(input logic [23:0] p, input logic [23:0] q);
    int unsigned lane [3];
    int unsigned d;
    int unsigned cap;
    for (int k = 0; k < 3; k++) begin
      if (p[k*8 +: 8] >= q[k*8 +: 8]) d = p[k*8 +: 8] - q[k*8 +: 8];
      else d = q[k*8 +: 8] - p[k*8 +: 8];
      lane[k] = (d * d) >> ((k == 0) ? 4 : 5);
      cap = (k == 0) ? 255 : 127;
      if (lane[k] > cap) lane[k] = cap;
    end
    return {lane[2][6:0], 1'b0, lane[1][6:0], 1'b0, lane[0][7:0]};
  endfunction

  // A carry into bit 8, 16 or 24 fills the byte below it with ones.
  function automatic logic [24:0] packed_sat_sum(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    logic [24:0] fill;
    s = {1'b0, a} + {1'b0, b};
    fill = '0;
    if (s[8]) fill[7:0] = 8'hff;
    if (s[16]) fill[15:8] = 8'hff;
    if (s[24]) fill[23:16] = 8'hff;
    return s | fill;
  endfunction

  function automatic block_word_t predict_block(input logic [23:0] pix, input logic restart);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic        core;
    logic [23:0] above_h;
    logic [23:0] own_h;
    logic [23:0] own_v;
    block_word_t res;
    w = (width_reg > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : width_reg;
    h = (height_reg > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : height_reg;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (restart) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = (col_pos >= MAX_GRID_WIDTH) ? 0 : col_pos;
    row = row_pos;
    core = col >= 1 && col + 2 <= w && row >= 1 && row + 2 <= h;
    above_h = above_hgrad[col];
    own_h = core ? edge_strength(pix, prev_pix) : 24'h0;
    own_v = core ? edge_strength(pix, above_pix[col]) : 24'h0;

    res = '0;
    res.interior = core;
    res.col = col[8:0];
    res.row = row[9:0];
    if (core) begin
      res.above_left = packed_sat_sum(above_h, prev_vgrad);
      res.above_own  = packed_sat_sum(above_h, own_v);
      res.own_left   = packed_sat_sum(own_h, prev_vgrad);
      res.own_own    = packed_sat_sum(own_h, own_v);
      res.hgrad      = own_h;
      res.vgrad      = own_v;
    end

    above_hgrad[col] = own_h;
    above_pix[col] = pix;
    prev_vgrad = own_v;
    prev_pix = pix;
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input block_word_t want,
                                 input logic [24:0] got_val, input logic [24:0] want_val);
    $display("mismatch in %s at col %0d row %0d: got %0h, expected %0h",
             field, want.col, want.row, got_val, want_val);
    mismatch_count++;
  endtask

  task automatic check_block(input block_word_t got);
    block_word_t want;
    if (expected_blocks.size() == 0) begin
      report_mismatch("unexpected word", got, 25'({got.row, got.col}), '0);
    end else begin
      want = expected_blocks.pop_front();
      if (got.interior !== want.interior)
        report_mismatch("interior", want, 25'(got.interior), 25'(want.interior));
      if (got.col !== want.col)
        report_mismatch("block_col", want, 25'(got.col), 25'(want.col));
      if (got.row !== want.row)
        report_mismatch("block_row", want, 25'(got.row), 25'(want.row));
      if (got.above_left !== want.above_left)
        report_mismatch("mix_above_left", want, got.above_left, want.above_left);
      if (got.above_own !== want.above_own)
        report_mismatch("mix_above_own", want, got.above_own, want.above_own);
      if (got.own_left !== want.own_left)
        report_mismatch("mix_own_left", want, got.own_left, want.own_left);
      if (got.own_own !== want.own_own)
        report_mismatch("mix_own_own", want, got.own_own, want.own_own);
      if (got.hgrad !== want.hgrad)
        report_mismatch("horiz_gradient", want, 25'(got.hgrad), 25'(want.hgrad));
      if (got.vgrad !== want.vgrad)
        report_mismatch("vert_gradient", want, 25'(got.vgrad), 25'(want.vgrad));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_blocks.delete();
      width_reg = GRID_WIDTH_RESET;
      height_reg = GRID_HEIGHT_RESET;
      prev_vgrad = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      // An output word can never belong to a pixel taken at the same edge.
      if (block_valid && block_ready)
        check_block({interior, block_col, block_row, mix_above_left, mix_above_own,
                     mix_own_left, mix_own_own, horiz_gradient, vert_gradient});
      if (pixel_valid && pixel_ready)
        expected_blocks.push_back(predict_block({red, green, blue}, frame_start));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
          REG_GRID_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
        endcase
      end
    end
    pending <= expected_blocks.size();
    failures <= mismatch_count;
  end

endmodule

FILE: tb/block_edge_video_effect_tb.sv
module block_edge_video_effect_tb;
  import edgefx_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  localparam logic [23:0] CORNER_FRAME [0:15] = '{
    24'h000000, 24'hffffff, 24'h000000, 24'hffffff,
    24'hffffff, 24'h000000, 24'h204010, 24'h000000,
    24'h00ff00, 24'h7f7f7f, 24'h808080, 24'hff00ff,
    24'h000000, 24'hffffff, 24'h123456, 24'habcdef
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic                  frame_start = 1'b0;
  logic                  block_valid;
  logic                  block_ready = 1'b0;
  logic                  interior;
  logic [8:0]            block_col;
  logic [9:0]            block_row;
  logic [24:0]           mix_above_left;
  logic [24:0]           mix_above_own;
  logic [24:0]           mix_own_left;
  logic [24:0]           mix_own_own;
  logic [23:0]           horiz_gradient;
  logic [23:0]           vert_gradient;

  int          failures;
  int          pending;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 17;
  int          stall_pct = 17;
  logic [23:0] last_pixel = '0;

  block_edge_video_effect u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue), .frame_start(frame_start),
    .block_valid(block_valid), .block_ready(block_ready),
    .interior(interior), .block_col(block_col), .block_row(block_row),
    .mix_above_left(mix_above_left), .mix_above_own(mix_above_own),
    .mix_own_left(mix_own_left), .mix_own_own(mix_own_own),
    .horiz_gradient(horiz_gradient), .vert_gradient(vert_gradient)
  );

  edgefx_block_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue), .frame_start(frame_start),
    .block_valid(block_valid), .block_ready(block_ready),
    .interior(interior), .block_col(block_col), .block_row(block_row),
    .mix_above_left(mix_above_left), .mix_above_own(mix_above_own),
    .mix_own_left(mix_own_left), .mix_own_own(mix_own_own),
    .horiz_gradient(horiz_gradient), .vert_gradient(vert_gradient),
    .failures(failures), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    block_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int clamp_dim(input int value, input int max_value);
    if (value == 0) return 1;
    return (value > max_value) ? max_value : value;
  endfunction

  // A quarter of the channels stay close to the previous word so that gradients
  // below the clamp show up, the rest are extremes or anything at all.
  function automatic logic [23:0] random_pixel(input logic [23:0] near);
    logic [23:0] p;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0:       p[k*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        1:       p[k*8 +: 8] = near[k*8 +: 8] + 8'($urandom_range(0, 70)) - 8'd35;
        default: p[k*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(input logic [23:0] pix, input logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    {red, green, blue} <= pix;
    frame_start <= restart;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    items_sent++;
    last_pixel = pix;
  endtask

  // Holds the sender off until every block word has come back. The count
  // is registered, so it lags the queue, and the first edge is waited out.
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input int cols, input int rows);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = CFG_DATA_W'(cols);
    // The width register ignores the top data bit.
    if (cols < 1024 && $urandom_range(0, 1) == 1) wdata[CFG_DATA_W-1] = 1'b1;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= wdata;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int cols, input int rows, input int count);
    configure(cols, rows);
    for (int i = 0; i < count; i++) begin
      if (items_sent >= 700 && items_sent < 1000) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end else begin
        send_idle_pct = 17;
        stall_pct = 17;
      end
      if ($urandom_range(0, 99) == 0) drain();
      send_pixel(random_pixel(last_pixel), i == 0 || $urandom_range(0, 199) == 0);
    end
  endtask

  initial begin
    int cols;
    int rows;
    int count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A few border words at the reset grid size.
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h80017f, 1'b0);

    configure(4, 4);
    for (int i = 0; i < 16; i++) send_pixel(CORNER_FRAME[i], i == 0);
    // Restart in the middle of a frame.
    for (int i = 0; i < 6; i++) send_pixel(random_pixel(last_pixel), i == 3);
    drain();

    // Widest grid: the first row and the start of the second.
    run_phase(512, 3, 520);

    while (items_sent < 1430) begin
      case ($urandom_range(0, 9))
        0: begin
          cols = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(3, 8);
          rows = (cols < 3) ? $urandom_range(0, 6) : $urandom_range(0, 2);
          count = 24;
        end
        1: begin
          cols = $urandom_range(3, 6);
          case ($urandom_range(0, 2))
            0:       rows = 1024;
            1:       rows = 1025;
            default: rows = 2047;
          endcase
          count = cols * $urandom_range(4, 12);
        end
        2: begin
          cols = $urandom_range(0, 1) ? 513 : 1023;
          rows = $urandom_range(3, 4);
          count = 40;
        end
        default: begin
          cols = $urandom_range(3, 10);
          rows = $urandom_range(3, 8);
          count = clamp_dim(cols, MAX_GRID_WIDTH) * clamp_dim(rows, MAX_GRID_HEIGHT)
                  * $urandom_range(1, 3);
        end
      endcase
      run_phase(cols, rows, count);
    end

    drain();
    if (failures == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
